/* rtl/core/bcflt_pkg.sv */
// bcflt_pkg: shared types, character codes and the per-byte scan function
// for the brace and comment fold level tracker
// no dependencies
`default_nettype none

package bcflt_pkg;

    localparam int LEVEL_W             = 12;
    localparam int LINE_INDEX_BITS_DEF = 16;
    localparam int OUT_DEPTH           = 4;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 12'd4095;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 12'd1024;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_COMMENT = 2'd1,
        MODE_STRING  = 2'd2
    } mode_t;

    // outcome of scanning one byte
    typedef struct packed {
        mode_t              mode;
        logic [LEVEL_W-1:0] level;
        logic               eol;
        logic               crlf;
    } scan_t;

    // one queued result without its line index
    typedef struct packed {
        logic [LEVEL_W-1:0] fold_level;
        logic               is_header;
        logic               last_line;
    } res_t;

    function automatic logic [LEVEL_W-1:0] level_inc(input logic [LEVEL_W-1:0] lvl);
        level_inc = (lvl < LEVEL_MAX) ? lvl + LEVEL_W'(1) : lvl;
    endfunction

    function automatic logic [LEVEL_W-1:0] level_dec(input logic [LEVEL_W-1:0] lvl);
        level_dec = (lvl != '0) ? lvl - LEVEL_W'(1) : lvl;
    endfunction

    function automatic scan_t scan_byte(
        input mode_t              mode,
        input logic [7:0]         prior,
        input logic [LEVEL_W-1:0] level,
        input logic [7:0]         cur,
        input logic [7:0]         nxt
    );
        scan_t s;
        s.mode  = mode;
        s.level = level;
        s.crlf  = (cur == CH_CR) && (nxt == CH_LF);
        s.eol   = s.crlf || (cur == CH_LF);
        case (mode)
            MODE_COMMENT:
            begin
                if (cur == CH_STAR && nxt == CH_SLASH)
                begin
                    s.level = level_dec(level);
                    s.mode  = MODE_NORMAL;
                end
            end
            MODE_STRING:
            begin
                if (cur == CH_QUOTE && prior != CH_BSLASH)
                begin
                    s.mode = MODE_NORMAL;
                end
            end
            default:
            begin
                // normal mode, also the unused code
                s.mode = MODE_NORMAL;
                if (cur == CH_LBRACE)
                begin
                    s.level = level_inc(level);
                end
                if (cur == CH_RBRACE)
                begin
                    s.level = level_dec(level);
                end
                if (cur == CH_SLASH && nxt == CH_STAR)
                begin
                    s.level = level_inc(level);
                    s.mode  = MODE_COMMENT;
                end
                if (cur == CH_QUOTE)
                begin
                    s.mode = MODE_STRING;
                end
            end
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/brace_comment_fold_level_tracker.sv */
// brace_comment_fold_level_tracker: top level, byte scanner plus result queue, uses bcflt_pkg
// queueing: a line's result enters the queue at the edge that accepts the request closing it
//   (the byte after its line end, or the last byte); it can be taken from the next cycle on
// throughput: one byte request per cycle; the last byte may queue two results and the four-entry
//   queue drains one per cycle when out_stall is low; input stalls only with under two slots free
// reset: levels load 1024, mode normal, no held byte, queue empty
`default_nettype none

module brace_comment_fold_level_tracker #(
    parameter int LINE_INDEX_BITS = bcflt_pkg::LINE_INDEX_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // byte request channel
    input  wire logic                              in_valid,
    output      logic                              in_stall,
    input  wire logic [7:0]                        text_byte,
    input  wire logic                              end_of_text,
    // line result channel
    output      logic                              out_valid,
    input  wire logic                              out_stall,
    output      logic [LINE_INDEX_BITS-1:0]        line_index,
    output      logic [bcflt_pkg::LEVEL_W-1:0]     fold_level,
    output      logic                              is_header,
    output      logic                              last_line,
    // base level register
    input  wire logic                              cfg_wr_en,
    input  wire logic [bcflt_pkg::LEVEL_W-1:0]     cfg_wr_data
);
    import bcflt_pkg::*;

    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    // scanner state
    logic [LEVEL_W-1:0]         base_level_reg, base_level_next;
    logic [7:0]                 held_byte_reg, held_byte_next;
    logic                       held_valid_reg, held_valid_next;
    mode_t                      mode_reg, mode_next;
    logic [7:0]                 prior_reg, prior_next;
    logic [LEVEL_W-1:0]         start_level_reg, start_level_next;
    logic [LEVEL_W-1:0]         run_level_reg, run_level_next;
    logic [LINE_INDEX_BITS-1:0] line_ctr_reg, line_ctr_next;
    logic                       skip_lf_reg, skip_lf_next;

    // result queue
    logic [LINE_INDEX_BITS-1:0] idx_mem [OUT_DEPTH];
    res_t                       res_mem [OUT_DEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]           count_reg;

    logic                       in_acc, out_acc;
    logic                       push_a, push_b;
    res_t                       res_a, res_b;
    logic [LINE_INDEX_BITS-1:0] idx_a, idx_b;
    logic [1:0]                 push_cnt;

    // stall while the queue cannot take two results
    assign in_stall  = (count_reg > CNT_W'(OUT_DEPTH - 2));
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign out_acc   = out_valid && !out_stall;

    assign line_index = idx_mem[rd_ptr_reg];
    assign fold_level = res_mem[rd_ptr_reg].fold_level;
    assign is_header  = res_mem[rd_ptr_reg].is_header;
    assign last_line  = res_mem[rd_ptr_reg].last_line;

    // scan path: the held byte first (with the new byte as look-ahead), then
    // the new byte itself when it is the last one (look-ahead reads as nul)
    always_comb
    begin
        scan_t sa;
        scan_t sb;
        logic  skip;

        base_level_next  = base_level_reg;
        held_byte_next   = held_byte_reg;
        held_valid_next  = held_valid_reg;
        mode_next        = mode_reg;
        prior_next       = prior_reg;
        start_level_next = start_level_reg;
        run_level_next   = run_level_reg;
        line_ctr_next    = line_ctr_reg;
        skip_lf_next     = skip_lf_reg;
        push_a           = 1'b0;
        push_b           = 1'b0;
        res_a            = '0;
        res_b            = '0;
        idx_a            = line_ctr_reg;
        idx_b            = line_ctr_reg;
        skip             = skip_lf_reg;

        sa = scan_byte(mode_reg, prior_reg, run_level_reg, held_byte_reg, text_byte);

        if (in_acc)
        begin
            if (held_valid_reg)
            begin
                if (skip)
                begin
                    // lf of a cr lf pair already counted
                    skip = 1'b0;
                end
                else
                begin
                    mode_next      = sa.mode;
                    run_level_next = sa.level;
                    if (sa.eol)
                    begin
                        push_a           = 1'b1;
                        idx_a            = line_ctr_next;
                        res_a.fold_level = start_level_next;
                        res_a.is_header  = (sa.level > start_level_next);
                        res_a.last_line  = 1'b0;
                        line_ctr_next    = line_ctr_next + LINE_INDEX_BITS'(1);
                        start_level_next = sa.level;
                    end
                    prior_next = sa.crlf ? text_byte : held_byte_reg;
                    skip       = sa.crlf;
                end
            end

            sb = scan_byte(mode_next, prior_next, run_level_next, text_byte, CH_NUL);

            if (end_of_text)
            begin
                if (skip)
                begin
                    // trailing lf: the cr line end becomes the final result
                    res_a.last_line = 1'b1;
                end
                else
                begin
                    push_b           = 1'b1;
                    idx_b            = line_ctr_next;
                    res_b.fold_level = start_level_next;
                    res_b.is_header  = (sb.level > start_level_next);
                    res_b.last_line  = 1'b1;
                end
                // document done, back to the idle state with levels from the base register
                held_byte_next   = '0;
                held_valid_next  = 1'b0;
                mode_next        = MODE_NORMAL;
                prior_next       = CH_SPACE;
                start_level_next = base_level_reg;
                run_level_next   = base_level_reg;
                line_ctr_next    = '0;
                skip_lf_next     = 1'b0;
            end
            else
            begin
                held_byte_next  = text_byte;
                held_valid_next = 1'b1;
                skip_lf_next    = skip;
            end
        end
        else
        begin
            sb = scan_byte(mode_reg, prior_reg, run_level_reg, text_byte, CH_NUL);
        end

        // register write; between documents it also loads the levels
        if (cfg_wr_en)
        begin
            base_level_next = cfg_wr_data;
            if (!held_valid_reg)
            begin
                start_level_next = cfg_wr_data;
                run_level_next   = cfg_wr_data;
            end
        end
    end

    assign push_cnt = 2'(push_a) + 2'(push_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_level_reg  <= LEVEL_RESET;
            held_byte_reg   <= '0;
            held_valid_reg  <= 1'b0;
            mode_reg        <= MODE_NORMAL;
            prior_reg       <= CH_SPACE;
            start_level_reg <= LEVEL_RESET;
            run_level_reg   <= LEVEL_RESET;
            line_ctr_reg    <= '0;
            skip_lf_reg     <= 1'b0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            base_level_reg  <= base_level_next;
            held_byte_reg   <= held_byte_next;
            held_valid_reg  <= held_valid_next;
            mode_reg        <= mode_next;
            prior_reg       <= prior_next;
            start_level_reg <= start_level_next;
            run_level_reg   <= run_level_next;
            line_ctr_reg    <= line_ctr_next;
            skip_lf_reg     <= skip_lf_next;
            wr_ptr_reg      <= wr_ptr_reg + PTR_W'(push_cnt);
            rd_ptr_reg      <= rd_ptr_reg + PTR_W'(out_acc);
            count_reg       <= count_reg + CNT_W'(push_cnt) - CNT_W'(out_acc);
        end
    end

    // queue storage, no reset
    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            idx_mem[wr_ptr_reg] <= idx_a;
            res_mem[wr_ptr_reg] <= res_a;
        end
        if (push_b)
        begin
            idx_mem[push_a ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg] <= idx_b;
            res_mem[push_a ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg] <= res_b;
        end
    end

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(OUT_DEPTH))
        else $error("result queue overflow");

    // the last byte always yields at least one result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && end_of_text |-> push_cnt != 2'd0)
        else $error("last byte produced no result");

    // after the last byte nothing is held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && end_of_text |=> !held_valid_reg && !skip_lf_reg)
        else $error("state not cleared after end of text");

    // a skipped lf needs a held byte
    assert property (@(posedge clk) disable iff (!rst_n)
        skip_lf_reg |-> held_valid_reg)
        else $error("skip flag without held byte");

endmodule

`default_nettype wire

/* tb/tb_brace_comment_fold_level_tracker.sv */
// testbench for brace_comment_fold_level_tracker: directed and random documents,
// checked line by line against a fold level predictor kept in this file
// depends on bcflt_pkg and the brace_comment_fold_level_tracker rtl
`timescale 1ns / 1ps

module tb_brace_comment_fold_level_tracker;

    import bcflt_pkg::*;

    localparam int LINE_BITS    = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int PRINT_LIMIT  = 60;
    localparam int PHASE_BYTES  = 410;

    // one finished line as the block reports it
    typedef struct packed {
        logic [LINE_BITS-1:0] line_index;
        logic [LEVEL_W-1:0]   fold_level;
        logic                 is_header;
        logic                 last_line;
    } line_result_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [7:0]           text_byte   = 8'h00;
    logic                 end_of_text = 1'b0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic [LINE_BITS-1:0] line_index;
    logic [LEVEL_W-1:0]   fold_level;
    logic                 is_header;
    logic                 last_line;
    logic                 cfg_wr_en   = 1'b0;
    logic [LEVEL_W-1:0]   cfg_wr_data = '0;

    // idling controls, percent of cycles
    int idle_pct   = 0;
    int stall_pct  = 0;
    int quiet_left = 0;

    int errors      = 0;
    int cycle_count = 0;
    int bytes_sent  = 0;

    // lines still owed by the block, oldest first
    line_result_t line_results[$];
    // lines closed by the request being predicted
    line_result_t fresh_lines[$];
    line_result_t expected_line;

    // fold tracker state, mirrored here
    logic [LEVEL_W-1:0]   base_reg;
    logic [7:0]           held_char;
    bit                   held_ok;
    mode_t                scan_state;
    logic [7:0]           prev_char;
    logic [LEVEL_W-1:0]   line_open_level;
    logic [LEVEL_W-1:0]   depth;
    logic [LINE_BITS-1:0] line_num;
    bit                   pair_lf;

    brace_comment_fold_level_tracker #(
        .LINE_INDEX_BITS(LINE_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .line_index  (line_index),
        .fold_level  (fold_level),
        .is_header   (is_header),
        .last_line   (last_line),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // run limit, counts every cycle from time zero
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL brace_comment_fold_level_tracker");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // fold level predictor
    // ------------------------------------------------------------------

    // back to the idle state between documents, levels from the register
    task automatic clear_tracker();
        held_char       = 8'h00;
        held_ok         = 1'b0;
        scan_state      = MODE_NORMAL;
        prev_char       = CH_SPACE;
        line_open_level = base_reg;
        depth           = base_reg;
        line_num        = '0;
        pair_lf         = 1'b0;
    endtask

    // register write lands on the levels only when no byte is held
    task automatic apply_base_level(input logic [LEVEL_W-1:0] v);
        base_reg = v;
        if (!held_ok)
        begin
            line_open_level = v;
            depth           = v;
        end
    endtask

    task automatic close_line(input bit final_line);
        line_result_t r;
        r.line_index = line_num;
        r.fold_level = line_open_level;
        r.is_header  = (depth > line_open_level);
        r.last_line  = final_line;
        fresh_lines.push_back(r);
        line_num        = line_num + LINE_BITS'(1);
        line_open_level = depth;
    endtask

    // one byte with its look-ahead
    task automatic scan_char(input logic [7:0] c, input logic [7:0] n, input bit final_line);
        bit crlf;
        crlf = (c == CH_CR) && (n == CH_LF);
        case (scan_state)
            MODE_COMMENT:
            begin
                // star slash closes the comment and its level
                if (c == CH_STAR && n == CH_SLASH)
                begin
                    if (depth != '0)
                        depth = depth - LEVEL_W'(1);
                    scan_state = MODE_NORMAL;
                end
            end
            MODE_STRING:
            begin
                // escaped quote keeps the string open
                if (c == CH_QUOTE && prev_char != CH_BSLASH)
                    scan_state = MODE_NORMAL;
            end
            default:
            begin
                scan_state = MODE_NORMAL;
                if (c == CH_LBRACE && depth != LEVEL_MAX)
                    depth = depth + LEVEL_W'(1);
                if (c == CH_RBRACE && depth != '0)
                    depth = depth - LEVEL_W'(1);
                if (c == CH_SLASH && n == CH_STAR)
                begin
                    if (depth != LEVEL_MAX)
                        depth = depth + LEVEL_W'(1);
                    scan_state = MODE_COMMENT;
                end
                if (c == CH_QUOTE)
                    scan_state = MODE_STRING;
            end
        endcase
        if (crlf || c == CH_LF || final_line)
            close_line(final_line);
        // the lf of a cr lf pair is consumed here and skipped when it comes up
        if (crlf)
        begin
            prev_char = n;
            pair_lf   = 1'b1;
        end
        else
        begin
            prev_char = c;
        end
    endtask

    // one accepted byte request: queue the lines it closes
    task automatic predict_request(input logic [7:0] b, input bit last);
        line_result_t r;
        fresh_lines.delete();
        if (held_ok)
        begin
            if (pair_lf)
                pair_lf = 1'b0;
            else
                scan_char(held_char, b, 1'b0);
        end
        if (last)
        begin
            if (pair_lf)
            begin
                // cr lf ends the text: the cr's line end becomes the final one
                if (fresh_lines.size() > 0)
                begin
                    r = fresh_lines.pop_back();
                    r.last_line = 1'b1;
                    fresh_lines.push_back(r);
                end
            end
            else
            begin
                scan_char(b, CH_NUL, 1'b1);
            end
            clear_tracker();
        end
        else
        begin
            held_char = b;
            held_ok   = 1'b1;
        end
        foreach (fresh_lines[i])
            line_results.push_back(fresh_lines[i]);
    endtask

    // ------------------------------------------------------------------
    // result side: stall pattern and checker
    // ------------------------------------------------------------------

    // random stall with occasional quiet stretches
    always @(posedge clk)
    begin
        if (quiet_left > 0)
        begin
            quiet_left <= quiet_left - 1;
            out_stall  <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 2)
        begin
            quiet_left <= $urandom_range(8, 40);
            out_stall  <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (line_results.size() == 0)
            begin
                report_mismatch("line result with none pending, line_index", line_index, 0);
            end
            else
            begin
                expected_line = line_results.pop_front();
                if (line_index !== expected_line.line_index)
                    report_mismatch("line_index", line_index, expected_line.line_index);
                if (fold_level !== expected_line.fold_level)
                    report_mismatch("fold_level", fold_level, expected_line.fold_level);
                if (is_header !== expected_line.is_header)
                    report_mismatch("is_header", is_header, expected_line.is_header);
                if (last_line !== expected_line.last_line)
                    report_mismatch("last_line", last_line, expected_line.last_line);
            end
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // one byte request; valid stays up into the next call when there is no gap
    task automatic send_byte(input logic [7:0] b, input bit last, input bit no_gaps);
        if (!no_gaps)
        begin
            while ($urandom_range(0, 99) < idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid    <= 1'b1;
        text_byte   <= b;
        end_of_text <= last;
        do
            @(posedge clk);
        while (in_stall);
        predict_request(b, last);
        bytes_sent++;
    endtask

    task automatic send_doc(input logic [7:0] doc[$], input bit no_gaps);
        foreach (doc[i])
            send_byte(doc[i], i == doc.size() - 1, no_gaps);
    endtask

    task automatic send_text(input string s);
        logic [7:0] doc[$];
        for (int i = 0; i < s.len(); i++)
            doc.push_back(s[i]);
        send_doc(doc, 1'b0);
    endtask

    // drop valid, wait for every owed line, then let the pipeline settle
    task automatic wait_idle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (line_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_base_level(input logic [LEVEL_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        apply_base_level(v);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly structural characters so modes and levels get exercised
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return 8'($urandom_range(0, 255));
        if (r < 20) return 8'($urandom_range(8'h61, 8'h7A));
        if (r < 28) return CH_SPACE;
        if (r < 38) return CH_LBRACE;
        if (r < 47) return CH_RBRACE;
        if (r < 57) return CH_SLASH;
        if (r < 66) return CH_STAR;
        if (r < 74) return CH_QUOTE;
        if (r < 79) return CH_BSLASH;
        if (r < 87) return CH_CR;
        return CH_LF;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset base level, brace up on line 0, brace down at the end
    task automatic test_braces_and_lines();
        wait_idle();
        send_text("{\n}");
    endtask

    // slash star slash opens and closes, then a comment spans a line end
    task automatic test_comment_nesting();
        wait_idle();
        send_text("/*/*\n*/");
    endtask

    // escaped quote stays in the string, brace inside a string is ignored
    task automatic test_string_escapes();
        wait_idle();
        send_text("\"\\\"{\"}");
    endtask

    // lone cr, then cr lf as the last two bytes of the text
    task automatic test_line_ends();
        logic [7:0] doc[$];
        wait_idle();
        doc = '{CH_CR, CH_CR, CH_LF};
        send_doc(doc, 1'b0);
    endtask

    // level floor at base 0, with the smallest and largest byte values
    task automatic test_level_floor();
        logic [7:0] doc[$];
        wait_idle();
        write_base_level('0);
        doc = '{CH_RBRACE, CH_NUL, 8'hFF};
        send_doc(doc, 1'b0);
    endtask

    // level ceiling at base 4095, brace and comment opening both held at max
    task automatic test_level_ceiling();
        wait_idle();
        write_base_level(LEVEL_MAX);
        send_text("{\n/*");
    endtask

    // random documents under one idling pattern and one base level
    task automatic test_random_text(input int idle, input int stall,
                                    input logic [LEVEL_W-1:0] base);
        logic [7:0] doc[$];
        int         start;
        int         len;
        bit         noise;
        bit         burst;
        wait_idle();
        write_base_level(base);
        idle_pct  = idle;
        stall_pct = stall;
        start     = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES)
        begin
            doc.delete();
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 24);
            noise = ($urandom_range(0, 99) < 15);
            burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++)
                doc.push_back(noise ? 8'($urandom_range(0, 255)) : pick_char());
            send_doc(doc, burst);
        end
    endtask

    initial
    begin
        base_reg = LEVEL_RESET;
        clear_tracker();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_braces_and_lines();
        test_comment_nesting();
        test_string_escapes();
        test_line_ends();
        test_level_floor();
        test_level_ceiling();

        test_random_text(0, 0, LEVEL_W'($urandom_range(0, 4095)));
        test_random_text(78, 0, LEVEL_MAX - LEVEL_W'(1));
        test_random_text(0, 78, LEVEL_W'(1));
        test_random_text(34, 34, LEVEL_W'($urandom_range(0, 4095)));

        wait_idle();
        if (line_results.size() != 0)
            report_mismatch("line results never delivered, count", line_results.size(), 0);
        if (errors == 0)
            $display("PASS brace_comment_fold_level_tracker");
        else
            $display("FAIL brace_comment_fold_level_tracker");
        $finish;
    end

endmodule
